[hdl/ddo_pkg.sv]
package ddo_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W = 5;

  localparam logic [31:0] KGAIN = 32'd2608131496;

  localparam logic [31:0] LEFT_SCALE_RST  = 32'd2164261;
  localparam logic [31:0] RIGHT_SCALE_RST = 32'd2164261;
  localparam logic [31:0] TURN_GAIN_RST   = 32'd3333194752;

  localparam logic [1:0] REG_LEFT_SCALE  = 2'd0;
  localparam logic [1:0] REG_RIGHT_SCALE = 2'd1;
  localparam logic [1:0] REG_TURN_GAIN   = 2'd2;

  function automatic logic [31:0] atan_at(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

[hdl/ddo_if.sv]
interface ddo_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_count;
  logic signed [31:0] right_count;
  modport source (output valid, left_count, right_count, input ready);
  modport sink (input valid, left_count, right_count, output ready);
endinterface

interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] x_position;
  logic signed [47:0] y_position;
  logic [31:0]        heading_angle;
  modport source (output valid, x_position, y_position, heading_angle, input ready);
  modport sink (input valid, x_position, y_position, heading_angle, output ready);
endinterface

interface ddo_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/differential_drive_odometry.sv]
// Each input transaction passes through the wheel-scale multiplies, turn gain, fold, CORDIC gain
// correction, CORDIC rotation and pose update before the result is valid. One item at a time;
// input ready again right after the result transaction.
// The work is done on one shared 34x34 multiplier (6 uses) and one CORDIC step per cycle.
// Reset (rst_n low, synchronous): pose, previous counts and heading clear,
// scale and gain registers take their defaults; configuration is always ready.
module differential_drive_odometry (
  input  logic       clk,
  input  logic       rst_n,
  ddo_in_if.sink     in_ch,
  ddo_out_if.source  out_ch,
  ddo_cfg_if.sink    cfg_ch
);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_ML   = 13'b0000000000010,
    S_MR   = 13'b0000000000100,
    S_MD   = 13'b0000000001000,
    S_G0   = 13'b0000000010000,
    S_G1   = 13'b0000000100000,
    S_G2   = 13'b0000001000000,
    S_FOLD = 13'b0000010000000,
    S_K0   = 13'b0000100000000,
    S_K1   = 13'b0001000000000,
    S_K2   = 13'b0010000000000,
    S_ROT  = 13'b0100000000000,
    S_UPD  = 13'b1000000000000
  } state_t;

  localparam logic signed [56:0] DMAX = 57'sd281474976710656;
  localparam logic signed [52:0] PMAX = 53'sd140737488355327;
  localparam logic signed [52:0] PMIN = -53'sd140737488355328;
  localparam logic [ddo_pkg::STEP_W-1:0] LAST_STEP =
    ddo_pkg::STEP_W'(ddo_pkg::CORDIC_STEPS - 1);

  state_t state_r, state_nxt;

  logic [31:0]        ls_r, rs_r, tg_r;
  logic [31:0]        prev_l_r, prev_r_r, heading_r;
  logic signed [47:0] px_r, py_r;
  logic signed [31:0] dl_r, dr_r;
  logic signed [63:0] tl_r, dsub_r;
  logic signed [67:0] prod_r;
  logic signed [49:0] dist_r;
  logic [31:0]        lo_r, turn_r, klo_r;
  logic [48:0]        mag_r;
  logic               neg_r;
  logic signed [51:0] cx_r, cy_r;
  logic signed [33:0] z_r;
  logic [ddo_pkg::STEP_W-1:0] step_r;
  logic               ovalid_r;
  logic signed [47:0] ox_r, oy_r;
  logic [31:0]        oh_r;

  logic signed [33:0] mul_a, mul_b;
  logic signed [63:0] tr;
  logic signed [56:0] dsum, dhalf;
  logic signed [31:0] half;
  logic [31:0]        ang, ang2;
  logic               flip;
  logic signed [49:0] dist2, dabs;
  logic [65:0]        rsum;
  logic [49:0]        rv;
  logic signed [51:0] sx, sy;
  logic signed [33:0] at;
  logic signed [52:0] sumx, sumy;

  assign in_ch.ready = (state_r == S_IDLE) && !ovalid_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ovalid_r;
  assign out_ch.x_position = ox_r;
  assign out_ch.y_position = oy_r;
  assign out_ch.heading_angle = oh_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_ML: begin
        mul_a = 34'(dl_r);
        mul_b = $signed({2'b0, ls_r});
      end
      S_MR: begin
        mul_a = 34'(dr_r);
        mul_b = $signed({2'b0, rs_r});
      end
      S_G0: begin
        mul_a = $signed({2'b0, dsub_r[31:0]});
        mul_b = $signed({2'b0, tg_r});
      end
      S_G1: begin
        mul_a = $signed({2'b0, dsub_r[63:32]});
        mul_b = $signed({2'b0, tg_r});
      end
      S_K0: begin
        mul_a = $signed({18'b0, mag_r[15:0]});
        mul_b = $signed({2'b0, ddo_pkg::KGAIN});
      end
      S_K1: begin
        mul_a = $signed({1'b0, mag_r[48:16]});
        mul_b = $signed({2'b0, ddo_pkg::KGAIN});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    tr = prod_r[63:0];
    dsum = 57'(tl_r >>> 8) + 57'(tr >>> 8);
    dhalf = dsum >>> 1;
    half = $signed(turn_r) >>> 1;
    ang = heading_r + half;
    flip = ang[31] ^ ang[30];
    ang2 = flip ? ang + 32'h8000_0000 : ang;
    dist2 = flip ? -dist_r : dist_r;
    dabs = dist2[49] ? -dist2 : dist2;
    rsum = prod_r[65:0] + {34'b0, klo_r};
    rv = rsum[65:16];
    sx = cx_r >>> step_r;
    sy = cy_r >>> step_r;
    at = $signed({2'b0, ddo_pkg::atan_at(5'(step_r))});
    sumx = 53'(px_r) + 53'(cx_r);
    sumy = 53'(py_r) + 53'(cy_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_ch.valid && in_ch.ready) state_nxt = S_ML;
      S_ML:   state_nxt = S_MR;
      S_MR:   state_nxt = S_MD;
      S_MD:   state_nxt = S_G0;
      S_G0:   state_nxt = S_G1;
      S_G1:   state_nxt = S_G2;
      S_G2:   state_nxt = S_FOLD;
      S_FOLD: state_nxt = S_K0;
      S_K0:   state_nxt = S_K1;
      S_K1:   state_nxt = S_K2;
      S_K2:   state_nxt = S_ROT;
      S_ROT:  if (step_r == LAST_STEP) state_nxt = S_UPD;
      S_UPD:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      S_IDLE: begin
        dl_r <= in_ch.left_count - $signed(prev_l_r);
        dr_r <= in_ch.right_count - $signed(prev_r_r);
      end
      S_MR: tl_r <= prod_r[63:0];
      S_MD: begin
        dsub_r <= tr - tl_r;
        if (dhalf > DMAX) begin
          dist_r <= 50'(DMAX);
        end else if (dhalf < -DMAX) begin
          dist_r <= 50'(-DMAX);
        end else begin
          dist_r <= 50'(dhalf);
        end
      end
      S_G1: lo_r <= prod_r[63:32];
      S_G2: turn_r <= lo_r + prod_r[31:0];
      S_FOLD: begin
        neg_r <= dist2[49];
        mag_r <= dabs[48:0];
        z_r <= 34'($signed(ang2));
      end
      S_K1: klo_r <= prod_r[47:16];
      S_K2: begin
        cx_r <= neg_r ? -$signed({2'b0, rv}) : $signed({2'b0, rv});
        cy_r <= '0;
      end
      S_ROT: begin
        if (!z_r[33]) begin
          cx_r <= cx_r - sy;
          cy_r <= cy_r + sx;
          z_r <= z_r - at;
        end else begin
          cx_r <= cx_r + sy;
          cy_r <= cy_r - sx;
          z_r <= z_r + at;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ls_r <= ddo_pkg::LEFT_SCALE_RST;
      rs_r <= ddo_pkg::RIGHT_SCALE_RST;
      tg_r <= ddo_pkg::TURN_GAIN_RST;
      prev_l_r <= '0;
      prev_r_r <= '0;
      heading_r <= '0;
      px_r <= '0;
      py_r <= '0;
      step_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          ddo_pkg::REG_LEFT_SCALE:  ls_r <= cfg_ch.data;
          ddo_pkg::REG_RIGHT_SCALE: rs_r <= cfg_ch.data;
          ddo_pkg::REG_TURN_GAIN:   tg_r <= cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        prev_l_r <= in_ch.left_count;
        prev_r_r <= in_ch.right_count;
      end
      if (state_r == S_K2) step_r <= '0;
      else if (state_r == S_ROT) step_r <= step_r + 1'b1;
      if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      if (state_r == S_UPD) begin
        px_r <= (sumx > PMAX) ? 48'(PMAX) : (sumx < PMIN) ? 48'(PMIN) : 48'(sumx);
        py_r <= (sumy > PMAX) ? 48'(PMAX) : (sumy < PMIN) ? 48'(PMIN) : 48'(sumy);
        heading_r <= heading_r + turn_r;
        ovalid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_UPD) begin
      ox_r <= (sumx > PMAX) ? 48'(PMAX) : (sumx < PMIN) ? 48'(PMIN) : 48'(sumx);
      oy_r <= (sumy > PMAX) ? 48'(PMAX) : (sumy < PMIN) ? 48'(PMIN) : 48'(sumy);
      oh_r <= heading_r + turn_r;
    end
  end

endmodule

[hdl/ddo_checker.sv]
module ddo_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [47:0] x_position
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (!in_ready && !out_valid))
    else $error("not busy after input transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(x_position)))
    else $error("stalled result changed");

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .x_position (out_ch.x_position)
);
